### rtl/bss_pkg.sv
package bss_pkg;

    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

### rtl/bss_ifs.sv
interface bss_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [bss_pkg::OP_W-1:0]             op;
    logic signed [bss_pkg::DATA_W-1:0]    operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

interface bss_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [bss_pkg::STATUS_W-1:0]         status;
    logic signed [bss_pkg::DATA_W-1:0]    popped;
    logic                                 found;
    logic signed [bss_pkg::DATA_W-1:0]    top_value;
    logic                                 top_valid;
    logic [bss_pkg::FILL_W-1:0]           fill;

    modport source (output valid, output status, output popped, output found,
                    output top_value, output top_valid, output fill, input ready);
    modport sink   (input valid, input status, input popped, input found,
                    input top_value, input top_valid, input fill, output ready);
endinterface

interface bss_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bss_pkg::CAP_W-1:0]            capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

### rtl/bounded_stack_with_search_top.sv
// Bounded LIFO stack of signed 32-bit words held in a single-port-read,
// single-port-write synchronous memory of DEPTH entries. Each item is a push,
// pop or search; every item returns exactly one result carrying status, the
// popped word, the search hit flag, the top word, its valid flag and the fill
// count. The block works on one item at a time: in_ready is high only while
// the sequencer is idle. Push and the unused op code take 2 cycles from
// acceptance to the next ready, pop takes 2 cycles (3 when a new top must be
// read back from memory), and search takes 2 + k cycles, where k is the number
// of entries compared, one per cycle through the memory read port, bottom to
// top, stopping at the first hit (k is at most the fill level). A full output
// register that is not taken holds the sequencer in its finish step. The top
// entry is mirrored in a register so results never wait on memory for it.
// Capacity is written through the cfg channel at any time the block is idle
// and is clipped to DEPTH; it resets to 5.
module bounded_stack_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bss_cfg_if.sink    i_cfg,
    bss_in_if.sink     i_in,
    bss_out_if.source  o_out
);
    import bss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > CAP_W) ? LW : CAP_W;

    // stack memory, read data registered
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // sequencer and stack state
    t_state            r_state, n_state;
    logic [LW-1:0]     r_level, n_level;
    logic [DATA_W-1:0] r_top, n_top;        // copy of the top entry
    logic [LW-1:0]     r_idx, n_idx;        // next scan address
    logic [DATA_W-1:0] r_key, n_key;
    logic [CAP_W-1:0]  r_capacity;

    // result being built
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_popped, n_popped;
    logic              r_found, n_found;

    // output register
    logic              r_out_valid;
    t_status           r_o_status;
    logic [DATA_W-1:0] r_o_popped;
    logic              r_o_found;
    logic [DATA_W-1:0] r_o_top_value;
    logic              r_o_top_valid;
    logic [FILL_W-1:0] r_o_fill;

    // memory access controls
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              load_out;

    logic              in_fire;
    logic              out_free;
    t_op               in_op;
    logic [CW-1:0]     level_ext;
    logic [CW-1:0]     cap_eff;
    logic              full;
    logic [LW-1:0]     level_m2;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign in_op     = t_op'(i_in.op);
    assign level_ext = CW'(r_level);
    // capacity above the built depth is clipped
    assign cap_eff   = (CW'(r_capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(r_capacity);
    assign full      = level_ext >= cap_eff;
    assign level_m2  = r_level - LW'(2);

    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_op)
                        OP_POP: begin
                            // a new top must come back from memory
                            n_state = (r_level > LW'(1)) ? S_POP_RD : S_FINISH;
                        end
                        OP_SEARCH: begin
                            n_state = (r_level != '0) ? S_SCAN : S_FINISH;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_state = S_FINISH;
            end
            S_SCAN: begin
                // stop on a hit or after the last held entry
                if (r_rd_data == r_key || r_idx == r_level) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        load_out   = 1'b0;
        n_level    = r_level;
        n_top      = r_top;
        n_idx      = r_idx;
        n_key      = r_key;
        n_status   = r_status;
        n_popped   = r_popped;
        n_found    = r_found;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    n_found  = 1'b0;
                    case (in_op)
                        OP_PUSH: begin
                            if (full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_top   = i_in.operand;
                                n_level = r_level + LW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_level == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped = r_top;
                                n_level  = r_level - LW'(1);
                                rd_en    = (r_level > LW'(1));
                                rd_addr  = level_m2[AW-1:0];
                            end
                        end
                        OP_SEARCH: begin
                            if (r_level == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = LW'(1);
                                n_key   = i_in.operand;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_top = r_rd_data;
            end
            S_SCAN: begin
                // read data holds entry r_idx-1, next read overlaps the compare
                if (r_rd_data == r_key) begin
                    n_found = 1'b1;
                end else if (r_idx != r_level) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_idx   = r_idx + LW'(1);
                end
            end
            S_FINISH: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // stack memory: push writes at level, reads only in later cycles
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_level[AW-1:0]] <= i_in.operand;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_popped <= n_popped;
        r_found  <= n_found;
        if (load_out) begin
            r_o_status    <= r_status;
            r_o_popped    <= r_popped;
            r_o_found     <= r_found;
            r_o_top_value <= (r_level != '0) ? r_top : '0;
            r_o_top_valid <= (r_level != '0);
            r_o_fill      <= level_ext[FILL_W-1:0];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_o_status;
    assign o_out.popped    = r_o_popped;
    assign o_out.found     = r_o_found;
    assign o_out.top_value = r_o_top_value;
    assign o_out.top_valid = r_o_top_valid;
    assign o_out.fill      = r_o_fill;

endmodule

### rtl/bss_chk.sv
module bss_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [bss_pkg::STATUS_W-1:0]   i_status,
    input  logic [bss_pkg::DATA_W-1:0]     i_popped,
    input  logic                           i_found,
    input  logic [bss_pkg::DATA_W-1:0]     i_top_value,
    input  logic                           i_top_valid,
    input  logic [bss_pkg::FILL_W-1:0]     i_fill
);
    import bss_pkg::*;

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while another is in work");

    // a failed operation carries no popped word and no hit
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OVERFLOW || i_status == ST_EMPTY)
        |-> i_popped == '0 && !i_found)
        else $error("failed operation reports data");

    // an empty stack result shows no top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_EMPTY || !i_top_valid) |-> i_top_value == '0
        && !i_top_valid == (i_status == ST_EMPTY || !i_top_valid))
        else $error("empty stack shows a top entry");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_popped) && $stable(i_found) && $stable(i_top_value)
        && $stable(i_fill))
        else $error("stalled result changed");

endmodule

bind bounded_stack_with_search_top bss_chk u_bss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_popped    (o_out.popped),
    .i_found     (o_out.found),
    .i_top_value (o_out.top_value),
    .i_top_valid (o_out.top_valid),
    .i_fill      (o_out.fill)
);
